### sv/mstp_pkg.sv
// Package for the Prim spanning tree block: widths, codes and defaults.
// Used by minimum_spanning_tree_prim; depends on nothing.
`default_nettype none
package mstp_pkg;
    localparam int MAX_VERTICES_DEF = 64;
    localparam int MAX_ENTRIES_DEF  = 512;
    localparam int WEIGHT_BITS_DEF  = 32;
    localparam logic [1:0] ACT_LOAD    = 2'd0;
    localparam logic [1:0] ACT_CLEAR   = 2'd1;
    localparam logic [1:0] ACT_RUN     = 2'd2;
    localparam logic [1:0] ACT_IGNORED = 2'd3;
    localparam logic [1:0] REG_VCOUNT = 2'd0;
    localparam logic [1:0] REG_INITW  = 2'd1;
endpackage
`default_nettype wire

### sv/minimum_spanning_tree_prim.sv
// Prim minimum spanning tree over a loaded adjacency store.
// Top level; depends on mstp_pkg.
//
// Input words (s_axis): tuser = action; tdata = from, to, weight, start.
// load, clear and ignored actions leave s_tready high, so one such word per
// cycle while idle. A full store drops a load and sets store_full.
// run: an init sweep over the vertex_count vertices; per popped vertex a
// minimum search over the queued vertices, then a scan of the stored
// entries in the steps scan, read and update per entry; a final search finds
// the queue empty. Then one word per vertex in index order on m_axis, with
// tlast on the final vertex. A stalled receiver holds the word; s_tready is
// low for the whole run. Reset empties the store, clears store_full and
// sets vertex_count 64, init_weight 0. Registers over APB; the user must
// write them only while idle, as the block does not enforce it.
`default_nettype none
module minimum_spanning_tree_prim #(
    parameter int MAX_VERTICES = mstp_pkg::MAX_VERTICES_DEF,
    parameter int MAX_ENTRIES  = mstp_pkg::MAX_ENTRIES_DEF,
    parameter int WEIGHT_BITS  = mstp_pkg::WEIGHT_BITS_DEF
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    // from[5:0], to[11:6], weight[43:12], start[49:44], zero fill
    input  wire  [55:0] s_tdata,
    // action[1:0]
    input  wire  [1:0]  s_tuser,
    output logic        m_tvalid,
    input  wire         m_tready,
    // vertex[5:0], parent[12:6], tree_weight[44:13], zero fill
    output logic [47:0] m_tdata,
    // store_full[0]
    output logic        m_tuser,
    output logic        m_tlast,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [2:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int VB = $clog2(MAX_VERTICES);
    localparam int EB = $clog2(MAX_ENTRIES);
    localparam int WB = (WEIGHT_BITS < 32) ? WEIGHT_BITS : 32;
    localparam logic [3:0] S_IDLE = 4'd0, S_INIT = 4'd1, S_FIND = 4'd2,
        S_SCAN = 4'd3, S_RD = 4'd4, S_UPD = 4'd5, S_OUT = 4'd6, S_ORD = 4'd7,
        S_OWAIT = 4'd8;
    localparam logic [6:0] NOT_REACHED = 7'd64;

    typedef struct packed {
        logic [5:0]    from;
        logic [5:0]    to;
        logic [WB-1:0] w;
    } entry_t;

    entry_t        estore [MAX_ENTRIES];
    logic [WB-1:0] best_mem [MAX_VERTICES];
    logic [6:0]    par_mem [MAX_VERTICES];
    logic [MAX_VERTICES-1:0] queued_reg, done_reg;

    logic [3:0]  state_reg;
    logic [EB:0] total_reg;
    logic        full_reg;
    logic [6:0]  vcount_reg;
    logic [31:0] initw_reg;
    logic [6:0]  vc;
    logic [VB:0] idx_reg;
    logic [EB:0] eidx_reg;
    logic [VB-1:0] u_reg;
    logic        found_reg;
    logic [WB-1:0] ubest_reg;
    logic [5:0]  start_reg;
    entry_t      erd_reg;
    logic [WB-1:0] brd_reg;
    logic [6:0]  prd_reg;

    wire [WB-1:0] initw = initw_reg[WB-1:0];
    wire [WB-1:0] in_w  = s_tdata[12 +: WB];

    always_comb begin
        if (vcount_reg == 7'd0) vc = 7'd1;
        else if (32'(vcount_reg) > MAX_VERTICES) vc = 7'(MAX_VERTICES);
        else vc = vcount_reg;
    end

    wire acc = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b1) ? initw_reg : {25'd0, vcount_reg};

    wire [VB-1:0] iv = idx_reg[VB-1:0];
    wire [VB-1:0] ev = erd_reg.to[VB-1:0];
    wire to_ok = (7'(erd_reg.to) < vc) && !done_reg[ev];
    wire wless = $signed(erd_reg.w) < $signed(brd_reg);

    always_ff @(posedge aclk) begin
        if (state_reg == S_IDLE && acc && s_tuser == mstp_pkg::ACT_LOAD &&
            32'(total_reg) < MAX_ENTRIES)
            estore[total_reg[EB-1:0]] <= '{s_tdata[5:0], s_tdata[11:6], in_w};
        if (state_reg == S_SCAN)
            erd_reg <= estore[eidx_reg[EB-1:0]];
        if (state_reg == S_FIND || state_reg == S_OUT || state_reg == S_RD)
            brd_reg <= best_mem[(state_reg == S_RD) ? ev : iv];
        if (state_reg == S_OUT)
            prd_reg <= par_mem[iv];
        if (state_reg == S_INIT) begin
            best_mem[iv] <= initw;
            par_mem[iv] <= (iv == start_reg[VB-1:0] && 7'(start_reg) < vc) ?
                7'(start_reg) : NOT_REACHED;
        end
        if (state_reg == S_UPD && erd_reg.from[VB-1:0] == u_reg &&
            7'(erd_reg.from) < vc && to_ok && (!queued_reg[ev] || wless)) begin
            best_mem[ev] <= erd_reg.w;
            par_mem[ev] <= 7'(u_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE; total_reg <= '0; full_reg <= 1'b0;
            vcount_reg <= 7'd64; initw_reg <= '0; m_tvalid <= 1'b0;
            queued_reg <= '0; done_reg <= '0; idx_reg <= '0; eidx_reg <= '0;
            found_reg <= 1'b0; u_reg <= '0; ubest_reg <= '0; start_reg <= '0;
        end else begin
            if (psel && penable && pwrite) begin
                if ({1'b0, paddr[2]} == mstp_pkg::REG_VCOUNT) vcount_reg <= pwdata[6:0];
                else if ({1'b0, paddr[2]} == mstp_pkg::REG_INITW) initw_reg <= pwdata;
            end
            unique case (state_reg)
                S_IDLE: if (acc) begin
                    if (s_tuser == mstp_pkg::ACT_LOAD) begin
                        if (32'(total_reg) < MAX_ENTRIES) total_reg <= total_reg + 1'b1;
                        else full_reg <= 1'b1;
                    end else if (s_tuser == mstp_pkg::ACT_CLEAR) begin
                        total_reg <= '0; full_reg <= 1'b0;
                    end else if (s_tuser == mstp_pkg::ACT_RUN) begin
                        start_reg <= s_tdata[49:44]; idx_reg <= '0;
                        queued_reg <= '0; done_reg <= '0; state_reg <= S_INIT;
                    end
                end
                S_INIT: begin
                    if (7'(idx_reg) + 7'd1 == vc) begin
                        idx_reg <= '0; found_reg <= 1'b0;
                        if (7'(start_reg) < vc) begin
                            queued_reg[start_reg[VB-1:0]] <= 1'b1; state_reg <= S_FIND;
                        end else state_reg <= S_OUT;
                    end else idx_reg <= idx_reg + 1'b1;
                end
                S_FIND: begin
                    // brd_reg holds best of previous idx
                    if (idx_reg != '0 && queued_reg[VB'(idx_reg - 1'b1)] &&
                        (!found_reg || $signed(brd_reg) < $signed(ubest_reg))) begin
                        found_reg <= 1'b1; u_reg <= VB'(idx_reg - 1'b1);
                        ubest_reg <= brd_reg;
                    end
                    if (7'(idx_reg) == vc) begin
                        idx_reg <= '0; eidx_reg <= '0;
                        if (found_reg || (queued_reg[VB'(idx_reg - 1'b1)])) begin
                            state_reg <= S_SCAN;
                        end else state_reg <= S_OUT;
                    end else idx_reg <= idx_reg + 1'b1;
                end
                S_SCAN: begin
                    if (!found_reg) u_reg <= u_reg;
                    queued_reg[u_reg] <= 1'b0; done_reg[u_reg] <= 1'b1;
                    if (eidx_reg >= total_reg) begin
                        found_reg <= 1'b0; idx_reg <= '0; state_reg <= S_FIND;
                    end else state_reg <= S_RD;
                end
                S_RD: state_reg <= S_UPD;
                S_UPD: begin
                    if (erd_reg.from[VB-1:0] == u_reg && 7'(erd_reg.from) < vc && to_ok)
                        queued_reg[ev] <= 1'b1;
                    eidx_reg <= eidx_reg + 1'b1; state_reg <= S_SCAN;
                end
                S_OUT: state_reg <= S_ORD;
                S_ORD: begin
                    m_tvalid <= 1'b1;
                    m_tdata <= {3'd0, 32'($signed(brd_reg)), prd_reg, iv};
                    m_tlast <= (7'(idx_reg) + 7'd1 == vc);
                    m_tuser <= full_reg; state_reg <= S_OWAIT;
                end
                S_OWAIT: if (m_tready) begin
                    m_tvalid <= 1'b0;
                    if (m_tlast) state_reg <= S_IDLE;
                    else begin idx_reg <= idx_reg + 1'b1; state_reg <= S_OUT; end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTH
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_IDLE) |-> !s_tready) else $error("ready while busy");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("word dropped");
    a_total: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(total_reg) <= MAX_ENTRIES) else $error("store overflow");
    a_done_q: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_FIND) |-> ((queued_reg & done_reg) == '0))
        else $error("vertex both queued and done");
`endif
endmodule
`default_nettype wire

### test/tb_top.sv
// Testbench for minimum_spanning_tree_prim: loads adjacency entries, runs Prim
// searches and checks every emitted vertex word against a built-in predictor.
// Depends on mstp_pkg and the block's RTL.
`default_nettype none
module tb_top;

    localparam int NV = 64;
    localparam int NE = 512;
    localparam logic [6:0] NOT_REACHED = 7'd64;
    localparam longint LIMIT = 64'd3000000;

    typedef struct packed {
        logic [5:0]  vtx;
        logic [6:0]  parent;
        logic [31:0] weight;
        logic        last;
        logic        full;
    } tree_word_t;

    typedef struct {
        logic [1:0]  act;
        logic [5:0]  from_v;
        logic [5:0]  to_v;
        logic [31:0] wgt;
        logic [5:0]  start;
        logic        chk;
        logic [6:0]  exp_parent;
        logic [31:0] exp_weight;
    } stim_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    wire         s_tready;
    logic [55:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    wire         m_tvalid;
    logic        m_tready = 1'b0;
    wire  [47:0] m_tdata;
    wire         m_tuser;
    wire         m_tlast;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    wire  [31:0] prdata;
    wire         pready;

    minimum_spanning_tree_prim DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
        .prdata(prdata), .pready(pready)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // predictor state
    logic [5:0]         adj_from [NE];
    logic [5:0]         adj_to   [NE];
    logic signed [31:0] adj_wgt  [NE];
    int                 adj_total;
    logic               store_full;
    int                 vcount_reg;
    logic [31:0]        initw_reg;
    tree_word_t         expected_words[$];
    tree_word_t         pinned_words[$];
    logic               pinned_valid[$];
    int                 errors = 0;
    longint             cycles = 0;

    function automatic int active_vertices();
        if (vcount_reg == 0) return 1;
        if (vcount_reg > NV) return NV;
        return vcount_reg;
    endfunction

    task automatic predict_item(input logic [1:0] act, input logic [5:0] fv,
                                input logic [5:0] tv, input logic [31:0] w,
                                input logic [5:0] st);
        int vc;
        int u;
        bit found;
        logic signed [31:0] best [NV];
        logic [6:0]         par  [NV];
        bit                 queued [NV];
        bit                 done [NV];
        tree_word_t         tw;
        if (act == mstp_pkg::ACT_LOAD) begin
            if (adj_total >= NE) store_full = 1'b1;
            else begin
                adj_from[adj_total] = fv;
                adj_to[adj_total] = tv;
                adj_wgt[adj_total] = w;
                adj_total++;
            end
        end else if (act == mstp_pkg::ACT_CLEAR) begin
            adj_total = 0;
            store_full = 1'b0;
        end else if (act == mstp_pkg::ACT_RUN) begin
            vc = active_vertices();
            for (int i = 0; i < NV; i++) begin
                best[i] = initw_reg;
                par[i] = NOT_REACHED;
                queued[i] = 0;
                done[i] = 0;
            end
            if (st < vc) begin
                queued[st] = 1;
                par[st] = {1'b0, st};
                forever begin
                    found = 0;
                    u = 0;
                    for (int i = 0; i < vc; i++)
                        if (queued[i] && (!found || best[i] < best[u])) begin
                            u = i;
                            found = 1;
                        end
                    if (!found) break;
                    queued[u] = 0;
                    done[u] = 1;
                    for (int e = 0; e < adj_total; e++) begin
                        if (adj_from[e] != u || adj_to[e] >= vc || done[adj_to[e]]) continue;
                        if (!queued[adj_to[e]]) begin
                            queued[adj_to[e]] = 1;
                            best[adj_to[e]] = adj_wgt[e];
                            par[adj_to[e]] = 7'(u);
                        end else if (best[adj_to[e]] > adj_wgt[e]) begin
                            best[adj_to[e]] = adj_wgt[e];
                            par[adj_to[e]] = 7'(u);
                        end
                    end
                end
            end
            for (int i = 0; i < vc; i++) begin
                tw.vtx = 6'(i);
                tw.parent = par[i];
                tw.weight = best[i];
                tw.last = (i == vc - 1);
                tw.full = store_full;
                expected_words.push_back(tw);
            end
        end
    endtask

    task automatic send_word(input logic [1:0] act, input logic [5:0] fv,
                             input logic [5:0] tv, input logic [31:0] w,
                             input logic [5:0] st);
        int gap;
        gap = $urandom_range(0, 11);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= act;
        s_tdata <= {6'd0, st, w, tv, fv};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_item(act, fv, tv, w, st);
    endtask

    task automatic idle_input();
        s_tvalid <= 1'b0;
    endtask

    task automatic wait_drained();
        idle_input();
        while (expected_words.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic apb_write(input logic [1:0] idx, input logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx[0], 2'b00};
        pwdata <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == mstp_pkg::REG_VCOUNT) vcount_reg = int'(val[6:0]);
        else initw_reg = val;
        @(posedge aclk);
    endtask

    // receiver and checker
    always @(posedge aclk) begin
        tree_word_t got;
        tree_word_t want;
        if (aresetn) begin
            cycles <= cycles + 1;
            if (m_tvalid && m_tready) begin
                got.vtx = m_tdata[5:0];
                got.parent = m_tdata[12:6];
                got.weight = m_tdata[44:13];
                got.last = m_tlast;
                got.full = m_tuser;
                if (expected_words.size() == 0) begin
                    $display("%0t: unexpected word expected none actual %h", $time, got);
                    errors++;
                end else begin
                    want = expected_words.pop_front();
                    if (got.vtx !== want.vtx)
                        $display("%0t: vertex expected %0d actual %0d", $time, want.vtx, got.vtx);
                    if (got.parent !== want.parent)
                        $display("%0t: parent of %0d expected %0d actual %0d", $time,
                                 want.vtx, want.parent, got.parent);
                    if (got.weight !== want.weight)
                        $display("%0t: weight of %0d expected %0d actual %0d", $time,
                                 want.vtx, $signed(want.weight), $signed(got.weight));
                    if (got.last !== want.last)
                        $display("%0t: tlast expected %b actual %b", $time, want.last, got.last);
                    if (got.full !== want.full)
                        $display("%0t: store_full expected %b actual %b", $time,
                                 want.full, got.full);
                    if (got !== want) errors++;
                    if (pinned_valid.size() != 0) begin
                        if (pinned_valid.pop_front() && got !== pinned_words[0]) begin
                            $display("%0t: fixed row expected %h actual %h", $time,
                                     pinned_words[0], got);
                            errors++;
                        end
                        void'(pinned_words.pop_front());
                    end
                end
            end
            m_tready <= ($urandom_range(0, 3) == 0) ? 1'b1 : ($urandom_range(0, 11) == 0);
            if (cycles > LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    stim_row_t directed[$];

    function automatic stim_row_t row(input logic [1:0] a, input int f, input int t,
                                      input logic [31:0] w, input int s);
        stim_row_t r;
        r.act = a; r.from_v = 6'(f); r.to_v = 6'(t); r.wgt = w; r.start = 6'(s);
        r.chk = 0; r.exp_parent = '0; r.exp_weight = '0;
        return r;
    endfunction

    task automatic random_graph(input int nv, input int nedges);
        logic [5:0] a, b;
        logic [31:0] w;
        int kind;
        send_word(mstp_pkg::ACT_CLEAR, 6'($urandom), 6'($urandom), $urandom, 6'($urandom));
        for (int k = 0; k < nedges; k++) begin
            a = 6'($urandom_range(0, nv - 1));
            b = 6'($urandom_range(0, nv - 1));
            kind = $urandom_range(0, 3);
            w = (kind == 0) ? $urandom : $urandom_range(0, 20) - 10;
            if ($urandom_range(0, 15) == 0) b = 6'($urandom);
            send_word(mstp_pkg::ACT_LOAD, a, b, w, 6'($urandom));
            if ($urandom_range(0, 7) != 0) send_word(mstp_pkg::ACT_LOAD, b, a, w, 6'($urandom));
        end
        if ($urandom_range(0, 9) == 0)
            send_word(mstp_pkg::ACT_IGNORED, 6'($urandom), 6'($urandom), $urandom,
                      6'($urandom));
        send_word(mstp_pkg::ACT_RUN, 6'($urandom), 6'($urandom), $urandom,
                  6'($urandom_range(0, 5) == 0 ? $urandom : $urandom_range(0, nv - 1)));
    endtask

    initial begin
        stim_row_t r;
        int nv;
        adj_total = 0;
        store_full = 0;
        vcount_reg = 64;
        initw_reg = 0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // after reset: empty store, 64 vertices, only the start reached
        r = row(mstp_pkg::ACT_RUN, 0, 0, 0, 5); directed.push_back(r);
        directed.push_back(row(mstp_pkg::ACT_LOAD, 0, 1, 32'h7fff_ffff, 0));
        directed.push_back(row(mstp_pkg::ACT_LOAD, 1, 0, 32'h7fff_ffff, 0));
        directed.push_back(row(mstp_pkg::ACT_LOAD, 0, 2, 32'h8000_0000, 63));
        directed.push_back(row(mstp_pkg::ACT_LOAD, 2, 0, 32'h8000_0000, 0));
        directed.push_back(row(mstp_pkg::ACT_LOAD, 2, 1, 32'hffff_ffff, 0));
        directed.push_back(row(mstp_pkg::ACT_LOAD, 1, 2, 32'hffff_ffff, 0));
        directed.push_back(row(mstp_pkg::ACT_LOAD, 3, 3, 32'd5, 0));
        directed.push_back(row(mstp_pkg::ACT_LOAD, 2, 63, 32'd1, 0));
        directed.push_back(row(mstp_pkg::ACT_LOAD, 63, 2, 32'd1, 0));
        directed.push_back(row(mstp_pkg::ACT_IGNORED, 63, 63, 32'hffff_ffff, 63));
        directed.push_back(row(mstp_pkg::ACT_RUN, 0, 0, 0, 0));
        directed.push_back(row(mstp_pkg::ACT_RUN, 63, 63, 0, 2));
        r = row(mstp_pkg::ACT_RUN, 0, 0, 0, 63); directed.push_back(r);
        directed.push_back(row(mstp_pkg::ACT_CLEAR, 63, 63, 32'hffff_ffff, 63));
        directed.push_back(row(mstp_pkg::ACT_RUN, 0, 0, 0, 3));
        foreach (directed[i]) begin
            if (i == 0) begin
                // fresh reset: start vertex 5 of 64 is its own parent, all others unreached
                for (int v = 0; v < 64; v++) begin
                    pinned_valid.push_back(1'b1);
                    pinned_words.push_back({6'(v), v == 5 ? 7'd5 : NOT_REACHED, 32'd0,
                                            v == 63, 1'b0});
                end
                send_word(directed[i].act, directed[i].from_v, directed[i].to_v,
                          directed[i].wgt, directed[i].start);
                wait_drained();
                apb_write(mstp_pkg::REG_VCOUNT, 32'd4);
                apb_write(mstp_pkg::REG_INITW, 32'h8000_0000);
                continue;
            end
            if (directed[i].act == mstp_pkg::ACT_RUN && directed[i].start == 63)
                for (int v = 0; v < 4; v++) begin
                    pinned_valid.push_back(1'b1);
                    pinned_words.push_back({6'(v), NOT_REACHED, 32'h8000_0000, v == 3, 1'b0});
                end
            else if (directed[i].act == mstp_pkg::ACT_RUN)
                for (int v = 0; v < 4; v++) begin
                    pinned_valid.push_back(1'b0);
                    pinned_words.push_back('0);
                end
            send_word(directed[i].act, directed[i].from_v, directed[i].to_v,
                      directed[i].wgt, directed[i].start);
        end
        wait_drained();

        // fill the store past its depth so the full flag sets
        apb_write(mstp_pkg::REG_VCOUNT, 32'd1);
        apb_write(mstp_pkg::REG_INITW, 32'h7fff_ffff);
        for (int k = 0; k < NE + 2; k++) begin
            s_tvalid <= 1'b1;
            s_tuser <= mstp_pkg::ACT_LOAD;
            s_tdata <= {6'd0, 6'(k), 32'(k * 7919), 6'(k >> 3), 6'(k)};
            @(posedge aclk);
            while (!s_tready) @(posedge aclk);
            predict_item(mstp_pkg::ACT_LOAD, 6'(k), 6'(k >> 3), 32'(k * 7919), 6'(k));
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        send_word(mstp_pkg::ACT_RUN, 0, 0, 0, 0);
        wait_drained();
        apb_write(mstp_pkg::REG_VCOUNT, 32'd64);
        send_word(mstp_pkg::ACT_RUN, 0, 0, 0, 0);
        wait_drained();
        apb_write(mstp_pkg::REG_VCOUNT, 32'd0);
        send_word(mstp_pkg::ACT_RUN, 0, 0, 0, 0);
        wait_drained();
        apb_write(mstp_pkg::REG_VCOUNT, 32'd127);
        send_word(mstp_pkg::ACT_RUN, 0, 0, 0, 9);
        wait_drained();

        // random graphs, small vertex counts mostly
        for (int g = 0; g < 24; g++) begin
            nv = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 12);
            apb_write(mstp_pkg::REG_VCOUNT, 32'(nv));
            apb_write(mstp_pkg::REG_INITW,
                      $urandom_range(0, 3) == 0 ? 32'h8000_0000 : $urandom);
            random_graph(nv, $urandom_range(0, 8));
            if (g % 6 == 5) wait_drained();
            else begin
                idle_input();
                while (expected_words.size() != 0) @(posedge aclk);
            end
            repeat (20) @(posedge aclk);
        end
        wait_drained();
        repeat (50) @(posedge aclk);
        if (errors == 0 && expected_words.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
`default_nettype wire
